// ===== rtl/hev_pkg.sv =====
package hev_pkg;

  // width of the running byte offset and the recorded code offset and length
  localparam int unsigned OffsetBits = 32;

  typedef logic [OffsetBits-1:0] ofs_t;

  // block tags after the attribute bits are masked off; the header tag is the full word
  localparam logic [29:0] TagCode    = 30'h3E9;
  localparam logic [29:0] TagData    = 30'h3EA;
  localparam logic [29:0] TagBss     = 30'h3EB;
  localparam logic [29:0] TagReloc32 = 30'h3EC;
  localparam logic [29:0] TagSymbol  = 30'h3F0;
  localparam logic [29:0] TagEnd     = 30'h3F2;
  localparam logic [31:0] TagHeader  = 32'h0000_03F3;

  // stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 224;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_NAMELEN,
    PH_TSIZE,
    PH_FIRST,
    PH_LAST,
    PH_TAG,
    PH_PLEN,
    PH_BSSLEN,
    PH_RCOUNT,
    PH_RHUNK,
    PH_SNAME,
    PH_SVAL
  } phase_e;

  // one input beat
  typedef struct packed {
    logic        word_present;
    logic [31:0] word;
    logic        last_item;
    logic [1:0]  tail_bytes;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic        valid_res;
    logic [31:0] hunks_declared;
    logic [31:0] code_hunks;
    logic [31:0] data_hunks;
    logic [31:0] bss_hunks;
    logic [29:0] reloc_entries;
    logic [31:0] code_offset;
    logic [31:0] code_bytes;
  } res_t;

endpackage

// ===== rtl/hunk_executable_validator_top.sv =====
// hunk executable validator
// input stream: one beat per big-endian longword of the file; tlast marks
// the end of the file (a beat with word_present low may carry only the end
// and the count of trailing bytes). output stream: one result beat per file,
// sent after the beat with tlast, holding the verdict and the counts.
// the input register holds each beat taken until the parse step moves it
// on; for the last beat the result is then written into the output
// register and shows on the master side from there.
// throughput: one beat per cycle while no last beat waits for the result
// slot, set by the single parse step from the input register to the state
// and result registers. when the receiver stalls the result waits in the
// output register; word beats keep flowing, and the next last beat waits
// in the input register with tready low until the result slot is free.
// reset clears the parser to the expect-magic phase and empties both
// registers; after every file the parser returns to that phase by itself.
module hunk_executable_validator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] word, [33:32] tail_bytes, [39:34] zero
  input  logic [hev_pkg::InDataW-1:0]   s_axis_tdata,
  // word_present
  input  logic                          s_axis_tuser,
  // last_item
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] valid_res, [32:1] hunks_declared, [64:33] code_hunks,
  // [96:65] data_hunks, [128:97] bss_hunks, [158:129] reloc_entries,
  // [190:159] code_offset, [222:191] code_bytes, [223] zero
  output logic [hev_pkg::OutDataW-1:0]  m_axis_tdata
);
  import hev_pkg::*;

  beat_t in_beat;
  beat_t held_beat;
  logic  held_valid;
  logic  advance;
  logic  out_free;
  logic  load;
  res_t  parse_res;
  res_t  out_res;

  // unpack the input beat
  always_comb begin
    in_beat.word_present = s_axis_tuser;
    in_beat.word         = s_axis_tdata[31:0];
    in_beat.last_item    = s_axis_tlast;
    in_beat.tail_bytes   = s_axis_tdata[33:32];
  end

  // a held beat moves on unless it ends a file and the result slot is busy
  assign advance = held_valid && (!held_beat.last_item || out_free);
  assign load    = advance && held_beat.last_item;

  hev_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .beat_i    (in_beat),
    .advance_i (advance),
    .valid_o   (held_valid),
    .beat_o    (held_beat)
  );

  hev_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .beat_i (held_beat),
    .res_o  (parse_res)
  );

  hev_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (parse_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the result beat
  assign m_axis_tdata = {1'b0,
                         out_res.code_bytes,
                         out_res.code_offset,
                         out_res.reloc_entries,
                         out_res.bss_hunks,
                         out_res.data_hunks,
                         out_res.code_hunks,
                         out_res.hunks_declared,
                         out_res.valid_res};

endmodule

// ===== rtl/hev_in_reg.sv =====
module hev_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  hev_pkg::beat_t beat_i,
  input  logic          advance_i,
  output logic          valid_o,
  output hev_pkg::beat_t beat_o
);
  import hev_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  // room when empty or when the held beat moves on this cycle
  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/hev_parse.sv =====
module hev_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  input  hev_pkg::beat_t beat_i,
  output hev_pkg::res_t  res_o
);
  import hev_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] skip_left_q, skip_left_d;
  ofs_t        word_offset_q, word_offset_d;
  logic [31:0] table_size_q, table_size_d;
  logic [31:0] first_index_q, first_index_d;
  logic [31:0] ends_seen_q, ends_seen_d;
  logic [31:0] payloads_seen_q, payloads_seen_d;
  logic        hunk_open_q, hunk_open_d;
  logic        is_code_q, is_code_d;
  logic [31:0] code_total_q, code_total_d;
  logic [31:0] data_total_q, data_total_d;
  logic [31:0] bss_total_q, bss_total_d;
  logic [29:0] reloc_total_q, reloc_total_d;
  ofs_t        first_code_at_q, first_code_at_d;
  ofs_t        first_code_len_q, first_code_len_d;
  logic        failed_q, failed_d;

  logic [29:0] tag;
  logic [32:0] span;
  logic        ok;
  logic        file_end;

  assign tag      = beat_i.word[29:0];
  assign span     = {1'b0, beat_i.word} - {1'b0, first_index_q} + 33'd1;
  assign file_end = go_i && beat_i.last_item;

  // next state for one word
  always_comb begin
    phase_d          = phase_q;
    skip_left_d      = skip_left_q;
    word_offset_d    = word_offset_q;
    table_size_d     = table_size_q;
    first_index_d    = first_index_q;
    ends_seen_d      = ends_seen_q;
    payloads_seen_d  = payloads_seen_q;
    hunk_open_d      = hunk_open_q;
    is_code_d        = is_code_q;
    code_total_d     = code_total_q;
    data_total_d     = data_total_q;
    bss_total_d      = bss_total_q;
    reloc_total_d    = reloc_total_q;
    first_code_at_d  = first_code_at_q;
    first_code_len_d = first_code_len_q;
    failed_d         = failed_q;
    if (go_i && beat_i.word_present) begin
      word_offset_d = word_offset_q + ofs_t'(4);
      if (!failed_q) begin
        if (skip_left_q != 32'd0) begin
          skip_left_d = skip_left_q - 32'd1;
        end else begin
          unique case (phase_q)
            PH_MAGIC: begin
              if (beat_i.word != TagHeader) failed_d = 1'b1;
              else phase_d = PH_NAMELEN;
            end
            PH_NAMELEN: begin
              if (beat_i.word == 32'd0) phase_d = PH_TSIZE;
              else skip_left_d = beat_i.word;
            end
            PH_TSIZE: begin
              table_size_d = beat_i.word;
              phase_d      = PH_FIRST;
            end
            PH_FIRST: begin
              first_index_d = beat_i.word;
              phase_d       = PH_LAST;
            end
            PH_LAST: begin
              if (first_index_q > beat_i.word || table_size_q == 32'd0 ||
                  span != {1'b0, table_size_q}) begin
                failed_d = 1'b1;
              end else begin
                skip_left_d = table_size_q;
                phase_d     = PH_TAG;
              end
            end
            PH_TAG: begin
              unique case (tag) inside
                TagEnd: begin
                  if (!hunk_open_q || ends_seen_q >= table_size_q) begin
                    failed_d = 1'b1;
                  end else begin
                    hunk_open_d = 1'b0;
                    ends_seen_d = ends_seen_q + 32'd1;
                  end
                end
                TagCode, TagData: begin
                  if (hunk_open_q) begin
                    failed_d = 1'b1;
                  end else begin
                    is_code_d = (tag == TagCode);
                    phase_d   = PH_PLEN;
                  end
                end
                TagBss: begin
                  if (hunk_open_q) failed_d = 1'b1;
                  else phase_d = PH_BSSLEN;
                end
                TagReloc32: begin
                  if (!hunk_open_q) failed_d = 1'b1;
                  else phase_d = PH_RCOUNT;
                end
                TagSymbol: begin
                  if (!hunk_open_q) failed_d = 1'b1;
                  else phase_d = PH_SNAME;
                end
                default: failed_d = 1'b1;
              endcase
            end
            PH_PLEN: begin
              if (payloads_seen_q >= table_size_q) begin
                failed_d = 1'b1;
              end else begin
                payloads_seen_d = payloads_seen_q + 32'd1;
                if (is_code_q) begin
                  if (code_total_q == 32'd0) begin
                    first_code_at_d  = word_offset_q + ofs_t'(4);
                    first_code_len_d = ofs_t'({beat_i.word, 2'b00});
                  end
                  code_total_d = code_total_q + 32'd1;
                end else begin
                  data_total_d = data_total_q + 32'd1;
                end
                skip_left_d = beat_i.word;
                hunk_open_d = 1'b1;
                phase_d     = PH_TAG;
              end
            end
            PH_BSSLEN: begin
              if (payloads_seen_q >= table_size_q) begin
                failed_d = 1'b1;
              end else begin
                payloads_seen_d = payloads_seen_q + 32'd1;
                bss_total_d     = bss_total_q + 32'd1;
                hunk_open_d     = 1'b1;
                phase_d         = PH_TAG;
              end
            end
            PH_RCOUNT: begin
              if (beat_i.word == 32'd0) begin
                phase_d = PH_TAG;
              end else begin
                reloc_total_d = reloc_total_q + beat_i.word[29:0];
                // the hunk number and the offsets follow, one word more than the count
                skip_left_d   = beat_i.word;
                phase_d       = PH_RHUNK;
              end
            end
            PH_RHUNK: phase_d = PH_RCOUNT;
            PH_SNAME: begin
              if (beat_i.word == 32'd0) begin
                phase_d = PH_TAG;
              end else begin
                skip_left_d = beat_i.word;
                phase_d     = PH_SVAL;
              end
            end
            PH_SVAL: phase_d = PH_SNAME;
            default: failed_d = 1'b1;
          endcase
        end
      end
    end
  end

  // final verdict from the state after this word
  assign ok = !failed_d && beat_i.tail_bytes == 2'd0 && skip_left_d == 32'd0 &&
              phase_d == PH_TAG && !hunk_open_d && table_size_d != 32'd0 &&
              ends_seen_d == table_size_d && payloads_seen_d == table_size_d;

  always_comb begin
    res_o.valid_res      = ok;
    res_o.hunks_declared = table_size_d;
    res_o.code_hunks     = code_total_d;
    res_o.data_hunks     = data_total_d;
    res_o.bss_hunks      = bss_total_d;
    res_o.reloc_entries  = reloc_total_d;
    res_o.code_offset    = 32'(first_code_at_d);
    res_o.code_bytes     = 32'(first_code_len_d);
  end

  // state registers, back to the start after the end of each file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_MAGIC;
      skip_left_q      <= '0;
      word_offset_q    <= '0;
      table_size_q     <= '0;
      first_index_q    <= '0;
      ends_seen_q      <= '0;
      payloads_seen_q  <= '0;
      hunk_open_q      <= 1'b0;
      is_code_q        <= 1'b0;
      code_total_q     <= '0;
      data_total_q     <= '0;
      bss_total_q      <= '0;
      reloc_total_q    <= '0;
      first_code_at_q  <= '0;
      first_code_len_q <= '0;
      failed_q         <= 1'b0;
    end else if (file_end) begin
      phase_q          <= PH_MAGIC;
      skip_left_q      <= '0;
      word_offset_q    <= '0;
      table_size_q     <= '0;
      first_index_q    <= '0;
      ends_seen_q      <= '0;
      payloads_seen_q  <= '0;
      hunk_open_q      <= 1'b0;
      is_code_q        <= 1'b0;
      code_total_q     <= '0;
      data_total_q     <= '0;
      bss_total_q      <= '0;
      reloc_total_q    <= '0;
      first_code_at_q  <= '0;
      first_code_len_q <= '0;
      failed_q         <= 1'b0;
    end else begin
      phase_q          <= phase_d;
      skip_left_q      <= skip_left_d;
      word_offset_q    <= word_offset_d;
      table_size_q     <= table_size_d;
      first_index_q    <= first_index_d;
      ends_seen_q      <= ends_seen_d;
      payloads_seen_q  <= payloads_seen_d;
      hunk_open_q      <= hunk_open_d;
      is_code_q        <= is_code_d;
      code_total_q     <= code_total_d;
      data_total_q     <= data_total_d;
      bss_total_q      <= bss_total_d;
      reloc_total_q    <= reloc_total_d;
      first_code_at_q  <= first_code_at_d;
      first_code_len_q <= first_code_len_d;
      failed_q         <= failed_d;
    end
  end

endmodule

// ===== rtl/hev_out_reg.sv =====
module hev_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  hev_pkg::res_t res_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output hev_pkg::res_t res_o
);
  import hev_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // slot is free when empty or drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== dv/hunk_executable_validator_top_tb.sv =====
`timescale 1ns / 100ps

module hunk_executable_validator_top_tb;
  import hev_pkg::*;

  // tag value that no block kind uses
  localparam logic [29:0] TagUnknown = 30'h3F1;
  // cycles without any beat moving before the run is abandoned
  localparam int unsigned StallLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 50;
  int unsigned n_fail = 0;
  int unsigned n_items = 0;
  int unsigned n_files = 0;
  int unsigned n_beats = 0;
  int unsigned n_verdicts = 0;
  int unsigned n_valid_files = 0;
  int unsigned stall_cycles = 0;

  // parser shadow state
  phase_e      parse_ph;
  logic [31:0] skip_cnt;
  logic [31:0] tbl_size;
  logic [31:0] first_idx;
  logic [31:0] end_cnt;
  logic [31:0] payload_cnt;
  logic [31:0] n_code;
  logic [31:0] n_data;
  logic [31:0] n_bss;
  logic [29:0] n_reloc;
  ofs_t        byte_ofs;
  ofs_t        code_at;
  ofs_t        code_len;
  logic        open_hunk;
  logic        cur_is_code;
  logic        broken;

  // verdicts for files whose last beat went in, oldest first
  res_t verdict_q[$];

  hunk_executable_validator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // back to the expect-magic state, after reset and after every file
  task automatic clear_parser();
    parse_ph    = PH_MAGIC;
    skip_cnt    = '0;
    tbl_size    = '0;
    first_idx   = '0;
    end_cnt     = '0;
    payload_cnt = '0;
    n_code      = '0;
    n_data      = '0;
    n_bss       = '0;
    n_reloc     = '0;
    byte_ofs    = '0;
    code_at     = '0;
    code_len    = '0;
    open_hunk   = 1'b0;
    cur_is_code = 1'b0;
    broken      = 1'b0;
  endtask

  initial clear_parser();

  // one longword through the structure parser
  task automatic hunk_parse_step(input logic [31:0] w);
    logic [29:0] tag;
    tag = w[29:0];
    if (skip_cnt != 32'd0) begin
      skip_cnt = skip_cnt - 32'd1;
      return;
    end
    case (parse_ph)
      PH_MAGIC: begin
        if (w != TagHeader) broken = 1'b1;
        else parse_ph = PH_NAMELEN;
      end
      PH_NAMELEN: begin
        if (w == 32'd0) parse_ph = PH_TSIZE;
        else skip_cnt = w;
      end
      PH_TSIZE: begin
        tbl_size = w;
        parse_ph = PH_FIRST;
      end
      PH_FIRST: begin
        first_idx = w;
        parse_ph  = PH_LAST;
      end
      PH_LAST: begin
        if (first_idx > w || tbl_size == 32'd0 ||
            ({1'b0, w} - {1'b0, first_idx} + 33'd1) != {1'b0, tbl_size}) begin
          broken = 1'b1;
        end else begin
          skip_cnt = tbl_size;
          parse_ph = PH_TAG;
        end
      end
      PH_TAG: begin
        if (tag == TagEnd) begin
          if (!open_hunk || end_cnt >= tbl_size) broken = 1'b1;
          else begin
            open_hunk = 1'b0;
            end_cnt   = end_cnt + 32'd1;
          end
        end else if (tag == TagCode || tag == TagData) begin
          if (open_hunk) broken = 1'b1;
          else begin
            cur_is_code = (tag == TagCode);
            parse_ph    = PH_PLEN;
          end
        end else if (tag == TagBss) begin
          if (open_hunk) broken = 1'b1;
          else parse_ph = PH_BSSLEN;
        end else if (tag == TagReloc32) begin
          if (!open_hunk) broken = 1'b1;
          else parse_ph = PH_RCOUNT;
        end else if (tag == TagSymbol) begin
          if (!open_hunk) broken = 1'b1;
          else parse_ph = PH_SNAME;
        end else begin
          broken = 1'b1;
        end
      end
      PH_PLEN: begin
        if (payload_cnt >= tbl_size) broken = 1'b1;
        else begin
          payload_cnt = payload_cnt + 32'd1;
          if (cur_is_code) begin
            if (n_code == 32'd0) begin
              code_at  = byte_ofs + ofs_t'(4);
              code_len = ofs_t'(64'(w) << 2);
            end
            n_code = n_code + 32'd1;
          end else begin
            n_data = n_data + 32'd1;
          end
          skip_cnt  = w;
          open_hunk = 1'b1;
          parse_ph  = PH_TAG;
        end
      end
      PH_BSSLEN: begin
        if (payload_cnt >= tbl_size) broken = 1'b1;
        else begin
          payload_cnt = payload_cnt + 32'd1;
          n_bss       = n_bss + 32'd1;
          open_hunk   = 1'b1;
          parse_ph    = PH_TAG;
        end
      end
      PH_RCOUNT: begin
        if (w == 32'd0) parse_ph = PH_TAG;
        else begin
          // hunk number plus the offsets follow
          n_reloc  = n_reloc + w[29:0];
          skip_cnt = w;
          parse_ph = PH_RHUNK;
        end
      end
      PH_RHUNK: parse_ph = PH_RCOUNT;
      PH_SNAME: begin
        if (w == 32'd0) parse_ph = PH_TAG;
        else begin
          skip_cnt = w;
          parse_ph = PH_SVAL;
        end
      end
      PH_SVAL: parse_ph = PH_SNAME;
      default: broken = 1'b1;
    endcase
  endtask

  // accepted input beat: advance the parser, queue a verdict at end of file
  task automatic apply_beat(input beat_t b);
    res_t r;
    if (b.word_present) begin
      if (!broken) hunk_parse_step(b.word);
      byte_ofs = byte_ofs + ofs_t'(4);
    end
    if (b.last_item) begin
      r.valid_res = !broken && b.tail_bytes == 2'd0 && skip_cnt == 32'd0 &&
                    parse_ph == PH_TAG && !open_hunk && tbl_size != 32'd0 &&
                    end_cnt == tbl_size && payload_cnt == tbl_size;
      r.hunks_declared = tbl_size;
      r.code_hunks     = n_code;
      r.data_hunks     = n_data;
      r.bss_hunks      = n_bss;
      r.reloc_entries  = n_reloc;
      r.code_offset    = 32'(code_at);
      r.code_bytes     = 32'(code_len);
      verdict_q.push_back(r);
      clear_parser();
    end
  endtask

  // input side monitor
  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      b.word_present = s_axis_tuser;
      b.word         = s_axis_tdata[31:0];
      b.tail_bytes   = s_axis_tdata[33:32];
      b.last_item    = s_axis_tlast;
      apply_beat(b);
      n_beats++;
    end
  end

  task automatic cmp_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // result side: every verdict beat against the oldest pending file
  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $error("result beat with no file pending");
        n_fail++;
      end else begin
        exp_r = verdict_q.pop_front();
        cmp_field("valid_res", 32'(exp_r.valid_res), 32'(m_axis_tdata[0]));
        cmp_field("hunks_declared", exp_r.hunks_declared, m_axis_tdata[32:1]);
        cmp_field("code_hunks", exp_r.code_hunks, m_axis_tdata[64:33]);
        cmp_field("data_hunks", exp_r.data_hunks, m_axis_tdata[96:65]);
        cmp_field("bss_hunks", exp_r.bss_hunks, m_axis_tdata[128:97]);
        cmp_field("reloc_entries", 32'(exp_r.reloc_entries), 32'(m_axis_tdata[158:129]));
        cmp_field("code_offset", exp_r.code_offset, m_axis_tdata[190:159]);
        cmp_field("code_bytes", exp_r.code_bytes, m_axis_tdata[222:191]);
        n_verdicts++;
        if (exp_r.valid_res) n_valid_files++;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles where no beat moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no beat accepted for %0d cycles", StallLimit);
      $display("** hunk_executable_validator_top: FAILED **");
      $finish;
    end
  end

  // drive one input beat and hold it until taken
  task automatic send_beat(input beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, b.tail_bytes, b.word};
    s_axis_tuser  <= b.word_present;
    s_axis_tlast  <= b.last_item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (b.word_present || b.last_item) n_items++;
  endtask

  // stream a file's longwords, with stray empty beats and a random end style
  task automatic stream_file(input logic [31:0] wq[$], input logic [1:0] tail);
    beat_t b;
    bit    end_alone;
    end_alone = (wq.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (wq[i]) begin
      if ($urandom_range(0, 19) == 0) begin
        b.word_present = 1'b0;
        b.word         = $urandom;
        b.last_item    = 1'b0;
        b.tail_bytes   = 2'($urandom);
        send_beat(b);
      end
      b.word_present = 1'b1;
      b.word         = wq[i];
      b.last_item    = !end_alone && (i == wq.size() - 1);
      b.tail_bytes   = b.last_item ? tail : 2'($urandom);
      send_beat(b);
    end
    if (end_alone) begin
      b.word_present = 1'b0;
      b.word         = $urandom;
      b.last_item    = 1'b1;
      b.tail_bytes   = tail;
      send_beat(b);
    end
    n_files++;
  endtask

  function automatic logic [29:0] pick_tag();
    case ($urandom_range(0, 6))
      0: return TagCode;
      1: return TagData;
      2: return TagBss;
      3: return TagReloc32;
      4: return TagSymbol;
      5: return TagEnd;
      default: return TagUnknown;
    endcase
  endfunction

  // well-formed file with random content, sometimes damaged or pure noise
  task automatic build_hunk_file(ref logic [31:0] wq[$]);
    int unsigned n_tbl, len, grp, cnt, pos, keep;
    logic [31:0] first;
    logic [1:0]  attr;
    wq.delete();
    wq.push_back(TagHeader);
    repeat ($urandom_range(0, 2)) begin
      len = $urandom_range(1, 3);
      wq.push_back(len);
      repeat (len) wq.push_back($urandom);
    end
    wq.push_back(32'd0);
    n_tbl = $urandom_range(1, 4);
    first = ($urandom_range(0, 3) == 0) ? ($urandom >> 1) : $urandom_range(0, 5);
    wq.push_back(n_tbl);
    wq.push_back(first);
    wq.push_back(first + n_tbl - 1);
    repeat (n_tbl) wq.push_back($urandom);
    repeat (n_tbl) begin
      attr = 2'($urandom);
      case ($urandom_range(0, 2))
        0, 1: begin
          wq.push_back({attr, ($urandom_range(0, 1) == 0) ? TagCode : TagData});
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
          wq.push_back(len);
          repeat (len) wq.push_back($urandom);
        end
        default: begin
          wq.push_back({attr, TagBss});
          wq.push_back($urandom);
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        wq.push_back({2'($urandom), TagReloc32});
        grp = $urandom_range(1, 2);
        repeat (grp) begin
          cnt = $urandom_range(1, 3);
          wq.push_back(cnt);
          wq.push_back($urandom_range(0, n_tbl - 1));
          repeat (cnt) wq.push_back($urandom);
        end
        wq.push_back(32'd0);
      end
      if ($urandom_range(0, 3) == 0) begin
        wq.push_back({2'($urandom), TagSymbol});
        repeat ($urandom_range(1, 2)) begin
          len = $urandom_range(1, 2);
          wq.push_back(len);
          repeat (len) wq.push_back($urandom);
          wq.push_back($urandom);
        end
        wq.push_back(32'd0);
      end
      wq.push_back({2'($urandom), TagEnd});
    end
    // damage about three files in ten
    case ($urandom_range(0, 9))
      7: begin
        pos = $urandom_range(0, wq.size() - 1);
        case ($urandom_range(0, 3))
          0: wq[pos] = $urandom;
          1: wq[pos] = {2'($urandom), pick_tag()};
          2: wq.insert(pos, {2'b00, TagEnd});
          default: wq.delete(pos);
        endcase
      end
      8: begin
        keep = $urandom_range(0, wq.size() - 1);
        while (wq.size() > keep) void'(wq.pop_back());
      end
      9: begin
        wq.delete();
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 0) wq.push_back($urandom);
          else wq.push_back({2'($urandom), pick_tag()});
        end
        if ($urandom_range(0, 1) == 0) wq[0] = TagHeader;
      end
      default: ;
    endcase
  endtask

  // end marker alone right after reset, with every tail bit set
  task automatic test_empty_file();
    logic [31:0] wq[$];
    stream_file(wq, 2'b11);
  endtask

  // all-ones first longword instead of the magic
  task automatic test_bad_magic();
    logic [31:0] wq[$];
    wq = {32'hFFFF_FFFF};
    stream_file(wq, 2'b00);
  endtask

  // one code hunk with a name, a relocation group and a symbol, tags with attribute bits
  task automatic test_full_featured_file();
    logic [31:0] wq[$];
    wq = {TagHeader, 32'd1, 32'h4C49_4221, 32'd0,
          32'd1, 32'd0, 32'd0, 32'd0,
          {2'b11, TagCode}, 32'd1, 32'hFFFF_FFFF,
          {2'b01, TagReloc32}, 32'd1, 32'd0, 32'd4, 32'd0,
          {2'b10, TagSymbol}, 32'd1, 32'h6D61_696E, 32'd0, 32'd0,
          {2'b10, TagEnd}};
    stream_file(wq, 2'b00);
  endtask

  // sender holds off until every pending verdict has come back
  task automatic test_drained_pause();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random_files(input int unsigned n_target, input int unsigned snd_idle,
                                   input int unsigned rcv_idle);
    logic [31:0] wq[$];
    int unsigned goal;
    send_idle_pct = snd_idle;
    recv_idle_pct = rcv_idle;
    goal = n_items + n_target;
    while (n_items < goal) begin
      build_hunk_file(wq);
      stream_file(wq, ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_file();
    test_bad_magic();
    test_full_featured_file();
    test_drained_pause();
    test_random_files(300, 37, 50);
    test_drained_pause();
    test_random_files(300, 50, 37);
    test_random_files(300, 0, 0);

    // let the last verdicts drain
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("streamed %0d files in %0d beats (%0d significant items)",
             n_files, n_beats, n_items);
    $display("checked %0d verdicts, %0d of them for structurally valid files",
             n_verdicts, n_valid_files);
    if (n_fail == 0) begin
      $display("** hunk_executable_validator_top: PASSED **");
    end else begin
      $display("** hunk_executable_validator_top: FAILED **");
    end
    $finish;
  end

endmodule
